[hdl/polyline_turn_point_filter_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the turn point filter
// Shared helpers so every check reads the same way.
// ---------------------------------------------------------------------------
`ifndef POLYLINE_TURN_POINT_FILTER_DEFINES_SVH
`define POLYLINE_TURN_POINT_FILTER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PTF_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("turn point filter: same-cycle check failed");

// next-cycle implication, quiet during reset
`define PTF_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("turn point filter: next-cycle check failed");

// next-cycle implication that also holds across reset
`define PTF_ASSERT_NEXT_ALWAYS(label, clk, cond, expr) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error("turn point filter: reset check failed");

`endif

[hdl/ptf_pkg.sv]
// ---------------------------------------------------------------------------
// ptf_pkg
// Widths, codes, transaction types and the arctangent table of the filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptf_pkg;

   // heading resolution and CORDIC length
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STEPS  = 16;
   localparam int ATAN_TAB_LEN  = 24;
   localparam int ATAN_IDX_BITS = 5;
   localparam int CORDIC_ITERS  = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
   localparam int STEP_BITS     = $clog2(CORDIC_ITERS);

   // field widths
   localparam int LAT_BITS   = 31;
   localparam int LON_BITS   = 32;
   localparam int DLAT_BITS  = LAT_BITS + 1;
   localparam int DLON_BITS  = LON_BITS + 1;
   localparam int SCALE_BITS = 16;
   localparam int THR_BITS   = 16;
   localparam int PROD_BITS  = DLON_BITS + SCALE_BITS + 1;
   localparam int Y_SHIFT    = 15;
   // room for the negated product plus CORDIC gain
   localparam int CORDIC_WIDTH = PROD_BITS + 2;
   localparam int CMP_BITS     = (ANGLE_BITS > THR_BITS) ? ANGLE_BITS : THR_BITS;

   localparam logic [ANGLE_BITS-1:0] ANGLE_HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};
   localparam logic [31:0]           Z_HALF_CIRCLE = 32'h8000_0000;
   localparam logic [31:0]           Z_ROUND = 32'd1 << (31 - ANGLE_BITS);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // configuration registers
   typedef enum logic [0:0] {
      CSR_TURN_THRESHOLD = 1'b0,
      CSR_LON_SCALE      = 1'b1
   } csr_index_type;

   localparam logic [THR_BITS-1:0]   THR_RESET   = 16'd910;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd32768;

   // position of a vertex within its polyline
   typedef enum logic [1:0] {
      KIND_OPEN   = 2'd0,   // first vertex
      KIND_SECOND = 2'd1,   // second vertex, first segment
      KIND_INNER  = 2'd2    // previous vertex is a middle vertex
   } kind_type;

   typedef struct packed {
      logic [LAT_BITS-1:0] lat;
      logic [LON_BITS-1:0] lon;
      logic [LAT_BITS-1:0] prev_lat;
      logic [LON_BITS-1:0] prev_lon;
      kind_type            kind;
      logic                fin;
   } entry_type;

   typedef struct packed {
      logic [LAT_BITS-1:0] lat;
      logic [LON_BITS-1:0] lon;
      logic                point_valid;
      logic                end_of_path;
   } rsp_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_START,
      B_HEADING,
      B_EMIT_MID,
      B_EMIT_LAST
   } back_state_type;

   typedef enum logic [1:0] {
      C_IDLE,
      C_PREP,
      C_ROTATE,
      C_DONE
   } cordic_state_type;

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_BITS-1:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[hdl/ptf_front.sv]
// ---------------------------------------------------------------------------
// ptf_front
// Accepts vertices, tags each with its place in the polyline and the vertex
// before it, and pushes the result into the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptf_front
   import ptf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [LAT_BITS-1:0] req_lat,
   input  wire logic [LON_BITS-1:0] req_lon,
   input  wire logic                req_fin,
   input  wire logic                queue_full,
   output logic                     push,
   output entry_type                push_entry
);

   kind_type            kind_ff, kind_in;
   logic [LAT_BITS-1:0] prev_lat_ff, prev_lat_in;
   logic [LON_BITS-1:0] prev_lon_ff, prev_lon_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_entry = '{lat: req_lat, lon: req_lon, prev_lat: prev_lat_ff,
                     prev_lon: prev_lon_ff, kind: kind_ff, fin: req_fin};
   end

   // vertex counter saturates at inner; a final vertex starts a new path
   always_comb begin
      kind_in     = kind_ff;
      prev_lat_in = prev_lat_ff;
      prev_lon_in = prev_lon_ff;
      if (push) begin
         prev_lat_in = req_lat;
         prev_lon_in = req_lon;
         if (req_fin) begin
            kind_in = KIND_OPEN;
         end else begin
            unique case (kind_ff)
               KIND_OPEN:   kind_in = KIND_SECOND;
               KIND_SECOND: kind_in = KIND_INNER;
               KIND_INNER:  kind_in = KIND_INNER;
               default:     kind_in = KIND_OPEN;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_OPEN;
      end else begin
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_lat_ff <= prev_lat_in;
      prev_lon_ff <= prev_lon_in;
   end

endmodule

`default_nettype wire

[hdl/ptf_queue.sv]
// ---------------------------------------------------------------------------
// ptf_queue
// Short FIFO of tagged vertices between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptf_queue
   import ptf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           empty,
   output entry_type      head
);

   entry_type              slots_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;

   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);

   assign full  = (count_ff == QCOUNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[hdl/ptf_cordic.sv]
// ---------------------------------------------------------------------------
// ptf_cordic
// Segment heading: scales the longitude delta, then runs a vectoring CORDIC
// one micro-rotation per cycle and rounds the angle to ANGLE_BITS.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptf_cordic
   import ptf_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [DLAT_BITS-1:0]  dlat,
   input  wire logic signed [DLON_BITS-1:0]  dlon,
   input  wire logic        [SCALE_BITS-1:0] scale,
   output logic                              done,
   output logic             [ANGLE_BITS-1:0] heading
);

   cordic_state_type               state_ff, state_in;
   logic signed [CORDIC_WIDTH-1:0] x_ff, x_in;
   logic signed [CORDIC_WIDTH-1:0] y_ff, y_in;
   logic        [31:0]             z_ff, z_in;
   logic        [STEP_BITS-1:0]    step_ff, step_in;

   logic signed [PROD_BITS-1:0]    prod;
   logic signed [CORDIC_WIDTH-1:0] x_shift;
   logic signed [CORDIC_WIDTH-1:0] y_shift;
   logic        [31:0]             atan_val;
   logic        [31:0]             z_rounded;
   logic                           y_positive;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(CORDIC_ITERS - 1);

   assign prod       = dlon * $signed({1'b0, scale});
   assign x_shift    = x_ff >>> step_ff;
   assign y_shift    = y_ff >>> step_ff;
   assign atan_val   = atan_entry(ATAN_IDX_BITS'(step_ff));
   assign y_positive = !y_ff[CORDIC_WIDTH-1] && (y_ff != '0);
   assign z_rounded  = z_ff + Z_ROUND;
   assign heading    = z_rounded[31 -: ANGLE_BITS];

   // sequencer: multiply, fold into right half-plane, rotate, report
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      done     = 1'b0;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               x_in     = CORDIC_WIDTH'(prod);
               y_in     = CORDIC_WIDTH'(dlat) <<< Y_SHIFT;
               state_in = C_PREP;
            end
         end
         C_PREP: begin
            step_in = '0;
            if (x_ff == '0 && y_ff == '0) begin
               // zero-length segment rounds to heading 0
               z_in     = '0;
               state_in = C_DONE;
            end else if (x_ff[CORDIC_WIDTH-1]) begin
               x_in     = -x_ff;
               y_in     = -y_ff;
               z_in     = Z_HALF_CIRCLE;
               state_in = C_ROTATE;
            end else begin
               z_in     = '0;
               state_in = C_ROTATE;
            end
         end
         C_ROTATE: begin
            if (y_positive) begin
               x_in = x_ff + y_shift;
               y_in = y_ff - x_shift;
               z_in = z_ff + atan_val;
            end else begin
               x_in = x_ff - y_shift;
               y_in = y_ff + x_shift;
               z_in = z_ff - atan_val;
            end
            if (step_ff == LAST_STEP) begin
               state_in = C_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         C_DONE: begin
            done     = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

endmodule

`default_nettype wire

[hdl/ptf_back.sv]
// ---------------------------------------------------------------------------
// ptf_back
// Takes tagged vertices from the queue, gets the segment heading, judges
// the turn at the previous vertex and emits waypoints and end markers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptf_back
   import ptf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  queue_empty,
   input  wire entry_type             head,
   output logic                       pop,
   input  wire logic [THR_BITS-1:0]   turn_threshold,
   input  wire logic [SCALE_BITS-1:0] lon_scale,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp
);

   back_state_type      state_ff, state_in;
   entry_type           cur_ff, cur_in;
   logic [ANGLE_BITS-1:0] prev_heading_ff, prev_heading_in;
   logic [LAT_BITS-1:0] emitted_lat_ff, emitted_lat_in;
   logic [LON_BITS-1:0] emitted_lon_ff, emitted_lon_in;
   logic                has_emitted_ff, has_emitted_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                        cordic_start;
   logic                        cordic_done;
   logic [ANGLE_BITS-1:0]       heading;
   logic signed [DLAT_BITS-1:0] dlat;
   logic signed [DLON_BITS-1:0] dlon;
   logic [ANGLE_BITS-1:0]       turn_raw;
   logic [ANGLE_BITS-1:0]       turn;
   logic                        keep_mid;
   logic                        mid_dup;
   logic                        last_dup;
   logic                        last_marker;
   logic                        out_free;

   // segment deltas, exact at one extra bit
   assign dlat = {cur_ff.lat[LAT_BITS-1], cur_ff.lat}
               - {cur_ff.prev_lat[LAT_BITS-1], cur_ff.prev_lat};
   assign dlon = {cur_ff.lon[LON_BITS-1], cur_ff.lon}
               - {cur_ff.prev_lon[LON_BITS-1], cur_ff.prev_lon};

   ptf_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .dlat    (dlat),
      .dlon    (dlon),
      .scale   (lon_scale),
      .done    (cordic_done),
      .heading (heading)
   );

   // wrapped absolute turn, in [0, half circle]
   assign turn_raw = heading - prev_heading_ff;
   assign turn     = (turn_raw > ANGLE_HALF) ? ANGLE_BITS'(-turn_raw) : turn_raw;
   assign keep_mid = (cur_ff.kind == KIND_INNER)
                  && (CMP_BITS'(turn) >= CMP_BITS'(turn_threshold));

   // repeats of the last emitted waypoint
   assign mid_dup  = has_emitted_ff && (cur_ff.prev_lat == emitted_lat_ff)
                  && (cur_ff.prev_lon == emitted_lon_ff);
   assign last_dup = has_emitted_ff && (cur_ff.lat == emitted_lat_ff)
                  && (cur_ff.lon == emitted_lon_ff);
   // lone final vertex or repeated final vertex gives an end marker
   assign last_marker = last_dup || (cur_ff.kind == KIND_OPEN && cur_ff.fin);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      prev_heading_in = prev_heading_ff;
      emitted_lat_in  = emitted_lat_ff;
      emitted_lon_in  = emitted_lon_ff;
      has_emitted_in  = has_emitted_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;
      pop             = 1'b0;
      cordic_start    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               cur_in   = head;
               state_in = (head.kind == KIND_OPEN) ? B_EMIT_LAST : B_START;
            end
         end
         B_START: begin
            cordic_start = 1'b1;
            state_in     = B_HEADING;
         end
         B_HEADING: begin
            if (cordic_done) begin
               prev_heading_in = heading;
               if (keep_mid) begin
                  state_in = B_EMIT_MID;
               end else if (cur_ff.fin) begin
                  state_in = B_EMIT_LAST;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         B_EMIT_MID: begin
            if (mid_dup) begin
               state_in = cur_ff.fin ? B_EMIT_LAST : B_IDLE;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in         = '{lat: cur_ff.prev_lat, lon: cur_ff.prev_lon,
                                  point_valid: 1'b1, end_of_path: 1'b0};
               emitted_lat_in = cur_ff.prev_lat;
               emitted_lon_in = cur_ff.prev_lon;
               has_emitted_in = 1'b1;
               state_in       = cur_ff.fin ? B_EMIT_LAST : B_IDLE;
            end
         end
         B_EMIT_LAST: begin
            if (last_marker && !cur_ff.fin) begin
               state_in = B_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               if (last_marker) begin
                  rsp_in = '{lat: '0, lon: '0, point_valid: 1'b0, end_of_path: 1'b1};
               end else begin
                  rsp_in = '{lat: cur_ff.lat, lon: cur_ff.lon,
                             point_valid: 1'b1, end_of_path: cur_ff.fin};
               end
               if (cur_ff.fin) begin
                  // path done: clear the emitted waypoint and the previous heading
                  emitted_lat_in  = '0;
                  emitted_lon_in  = '0;
                  has_emitted_in  = 1'b0;
                  prev_heading_in = '0;
               end else begin
                  emitted_lat_in = cur_ff.lat;
                  emitted_lon_in = cur_ff.lon;
                  has_emitted_in = 1'b1;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= B_IDLE;
         has_emitted_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         prev_heading_ff <= '0;
      end else begin
         state_ff        <= state_in;
         has_emitted_ff  <= has_emitted_in;
         rsp_valid_ff    <= rsp_valid_in;
         prev_heading_ff <= prev_heading_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      emitted_lat_ff <= emitted_lat_in;
      emitted_lon_ff <= emitted_lon_in;
      rsp_ff         <= rsp_in;
   end

endmodule

`default_nettype wire

[hdl/polyline_turn_point_filter.sv]
// ---------------------------------------------------------------------------
// polyline_turn_point_filter
// Keeps the first, the last and every sharply turning vertex of a polyline.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  req_*    | in        | req_tvalid/req_tready  | tdata lat, lon; tlast final
//  rsp_*    | out       | rsp_tvalid/rsp_tready  | tdata lat, lon; tuser valid;
//           |           |                        | tlast end of path
//  csr_*    | in        | csr_valid/csr_ready    | csr_index, csr_data
//
//  First vertex of a path: the back pops it from the queue and emits it.
//  Every later vertex goes through the heading unit (queue pop, one
//  multiply, one fold, 16 serial CORDIC rotations, one report); each
//  result is then emitted once the result register is free.
//  The front takes vertices while the two-entry queue has room; the result
//  register lets the back go on while a result waits to be taken.
//  Reset is synchronous and returns both registers to their defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polyline_turn_point_filter
   import ptf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // point_lat [30:0], point_lon [62:31], zero [63]
   input  wire logic [63:0]           req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // way_lat [30:0], way_lon [62:31], zero [63]
   output logic [63:0]                rsp_tdata,
   // point_valid [0]
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [0:0]            csr_index,
   input  wire logic [THR_BITS-1:0]   csr_data
);

   logic [THR_BITS-1:0]   thr_ff, thr_in;
   logic [SCALE_BITS-1:0] scale_ff, scale_in;

   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;
   entry_type head;
   rsp_type   rsp;

   // configuration registers, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      thr_in   = thr_ff;
      scale_in = scale_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TURN_THRESHOLD: thr_in   = csr_data;
            CSR_LON_SCALE:      scale_in = csr_data;
            default:            thr_in   = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THR_RESET;
         scale_ff <= SCALE_RESET;
      end else begin
         thr_ff   <= thr_in;
         scale_ff <= scale_in;
      end
   end

   ptf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_lat    (req_tdata[LAT_BITS-1:0]),
      .req_lon    (req_tdata[LAT_BITS+LON_BITS-1:LAT_BITS]),
      .req_fin    (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   ptf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   ptf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .head           (head),
      .pop            (pop),
      .turn_threshold (thr_ff),
      .lon_scale      (scale_ff),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp            (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.lon, rsp.lat};
   assign rsp_tuser = rsp.point_valid;
   assign rsp_tlast = rsp.end_of_path;

endmodule

`default_nettype wire

[hdl/ptf_checker.sv]
// ---------------------------------------------------------------------------
// ptf_checker
// Port-level checks on the result stream of the turn point filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "polyline_turn_point_filter_defines.svh"

module ptf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   // a stalled result keeps its contents
   `PTF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // an end marker closes the path and carries no coordinates
   `PTF_ASSERT_IMPLY(a_marker_form, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast && (rsp_tdata == 64'd0))

   // the padding bit of the result is always clear
   `PTF_ASSERT_IMPLY(a_rsp_pad, clock, reset, rsp_tvalid, !rsp_tdata[63])

   // nothing is offered right after reset
   `PTF_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid)

endmodule

bind polyline_turn_point_filter ptf_checker u_checker (.*);

`default_nettype wire
